[sv/kdb_pkg.sv]
// Package for the key debounce block with short/long press detection.
// Holds codes, widths and the structs passed between kdb_* modules.
// No dependencies.
package kdb_pkg;

  // Field and register widths
  localparam int unsigned DEB_W  = 8;
  localparam int unsigned HOLD_W = 16;
  localparam int unsigned CFG_W  = 16;

  // Configuration reset values
  localparam logic [DEB_W-1:0]  DEB_TICKS_RST  = DEB_W'(5);
  localparam logic [HOLD_W-1:0] LONG_TICKS_RST = HOLD_W'(100);

  // Configuration register indexes
  typedef enum logic {
    CFG_IDX_DEBOUNCE = 1'b0,
    CFG_IDX_LONG     = 1'b1
  } cfg_idx_t;

  // Item operation
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // Latched key event
  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_SHORT = 2'd1,
    EVT_LONG  = 2'd2
  } evt_t;

  // Active configuration
  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ticks;
    logic [HOLD_W-1:0] long_press_ticks;
  } kdb_cfg_t;

  // One input item as held in the input register
  typedef struct packed {
    op_t  operation;
    logic key_level;
  } kdb_item_t;

  // One result item
  typedef struct packed {
    evt_t event_code;
    logic key_pressed;
  } kdb_result_t;

endpackage

[sv/key_debounce_short_long_press_top.sv]
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle while the result side does not stall; the state
// update is a single pass of short logic between the two registers.
// Reset (rst_n, synchronous, active low): key released, previous level high,
// counters and event cleared, debounce_ticks = 5, long_press_ticks = 100.
module key_debounce_short_long_press_top import kdb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_operation,
  input  logic             in_key_level,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_event_code,
  output logic             out_key_pressed,
  // configuration write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic        in_valid_r;
  kdb_item_t   item_r;
  logic        out_valid_r;
  kdb_result_t res_r;
  kdb_result_t res;
  kdb_cfg_t    cfg;
  logic        out_free;
  logic        fire;
  logic        in_xfer;

  // Handshake control
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  kdb_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_idx_t'(cfg_index)),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.operation <= op_t'(in_operation);
      item_r.key_level <= in_key_level;
    end
  end

  kdb_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .cfg    (cfg),
    .result (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_r <= res;
  end

  assign out_valid       = out_valid_r;
  assign out_event_code  = res_r.event_code;
  assign out_key_pressed = res_r.key_pressed;

endmodule

[sv/kdb_cfg_regs.sv]
// Configuration register file for the key debounce block.
// Depends on kdb_pkg for widths, reset values and register indexes.
module kdb_cfg_regs import kdb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  cfg_idx_t         wr_index,
  input  logic [CFG_W-1:0] wr_data,
  output kdb_cfg_t         cfg
);

  logic [DEB_W-1:0]  debounce_ticks_r;
  logic [HOLD_W-1:0] long_press_ticks_r;

  // Register writes, truncated to each register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r   <= DEB_TICKS_RST;
      long_press_ticks_r <= LONG_TICKS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_IDX_DEBOUNCE: debounce_ticks_r   <= wr_data[DEB_W-1:0];
        CFG_IDX_LONG:     long_press_ticks_r <= wr_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.debounce_ticks   = debounce_ticks_r;
  assign cfg.long_press_ticks = long_press_ticks_r;

endmodule

[sv/kdb_engine.sv]
// Debounce and press-detect state with its single-pass update logic.
// Depends on kdb_pkg; state advances only when fire is high.
module kdb_engine import kdb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  kdb_item_t   item,
  input  kdb_cfg_t    cfg,
  output kdb_result_t result
);

  logic              pressed_r,  pressed_nxt;
  logic              prev_lvl_r, prev_lvl_nxt;
  logic [DEB_W-1:0]  run_r,      run_nxt;
  logic [HOLD_W-1:0] hold_r,     hold_nxt;
  logic              long_rep_r, long_rep_nxt;
  evt_t              pend_r,     pend_nxt;
  evt_t              code;

  // Next-state logic for one tick or read
  always_comb begin
    pressed_nxt  = pressed_r;
    prev_lvl_nxt = prev_lvl_r;
    run_nxt      = run_r;
    hold_nxt     = hold_r;
    long_rep_nxt = long_rep_r;
    pend_nxt     = pend_r;
    code         = EVT_NONE;

    if (item.operation == OP_TICK) begin
      // run of equal samples, saturating at the debounce threshold
      if (item.key_level == prev_lvl_r) begin
        if (run_r < cfg.debounce_ticks) run_nxt = run_r + DEB_W'(1);
      end else begin
        prev_lvl_nxt = item.key_level;
        run_nxt      = DEB_W'(1);
      end

      // accept a stable level
      if (run_nxt >= cfg.debounce_ticks) begin
        if (!pressed_r && !item.key_level) begin
          pressed_nxt  = 1'b1;
          hold_nxt     = '0;
          long_rep_nxt = 1'b0;
        end else if (pressed_r && item.key_level) begin
          pressed_nxt = 1'b0;
          if (!long_rep_r) pend_nxt = EVT_SHORT;
          hold_nxt     = '0;
          long_rep_nxt = 1'b0;
        end
      end

      // hold count; the accepting tick counts as the first hold tick
      if (pressed_nxt) begin
        if (hold_nxt < cfg.long_press_ticks) hold_nxt = hold_nxt + HOLD_W'(1);
        if (hold_nxt >= cfg.long_press_ticks && !long_rep_nxt) begin
          long_rep_nxt = 1'b1;
          pend_nxt     = EVT_LONG;
        end
      end
    end else begin
      // read and clear
      code     = pend_r;
      pend_nxt = EVT_NONE;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r  <= 1'b0;
      prev_lvl_r <= 1'b1;
      run_r      <= '0;
      hold_r     <= '0;
      long_rep_r <= 1'b0;
      pend_r     <= EVT_NONE;
    end else if (fire) begin
      pressed_r  <= pressed_nxt;
      prev_lvl_r <= prev_lvl_nxt;
      run_r      <= run_nxt;
      hold_r     <= hold_nxt;
      long_rep_r <= long_rep_nxt;
      pend_r     <= pend_nxt;
    end
  end

  assign result.event_code  = code;
  assign result.key_pressed = pressed_nxt;

endmodule

[bench/tb_top.sv]
// Testbench for key_debounce_short_long_press_top: directed table, then random press sequences.
// Each result is checked against a local key debounce model, or the typed directed row, under random stalls and gaps.
// Depends on kdb_pkg (sv/kdb_pkg.sv) and the RTL of the block.
module tb_top;
  import kdb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS    = 25;
  localparam int DIR_CFG_ROW = 21;  // thresholds drop to zero before this row
  localparam int HOLD_CYCLES = 300;

  // One directed row; the expected result is used only when typed is set
  typedef struct packed {
    op_t  op;
    logic lvl;
    logic typed;
    evt_t evt;
    logic pressed;
  } step_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  op_t              in_operation = OP_TICK;
  logic             in_key_level = 1'b1;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_event_code;
  logic             out_key_pressed;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_idx_t         cfg_index = CFG_IDX_DEBOUNCE;
  logic [CFG_W-1:0] cfg_data = '0;

  // Typed expectation travelling with the current transfer
  logic row_typed = 1'b0;
  evt_t row_evt = EVT_NONE;
  logic row_pressed = 1'b0;

  // Local copy of thresholds and key state
  logic [DEB_W-1:0]  deb_thr = DEB_TICKS_RST;
  logic [HOLD_W-1:0] long_thr = LONG_TICKS_RST;
  logic              pressed_st = 1'b0;
  logic              prev_lvl = 1'b1;
  logic [DEB_W-1:0]  run_cnt = '0;
  logic [HOLD_W-1:0] hold_cnt = '0;
  logic              long_seen = 1'b0;
  evt_t              latched_evt = EVT_NONE;

  kdb_result_t key_results_q[$];
  int          mismatch_cnt = 0;
  int          cycle_cnt = 0;

  // Stimulus generator state: current segment level and length
  logic seg_lvl = 1'b1;
  logic steady_lvl = 1'b1;
  int   seg_left = 0;

  step_row_t dir_rows [DIR_ROWS] = '{
    '{OP_READ, 1'b0, 1'b1, EVT_NONE,  1'b0},  // nothing latched after reset
    '{OP_READ, 1'b1, 1'b1, EVT_NONE,  1'b0},
    '{OP_TICK, 1'b1, 1'b1, EVT_NONE,  1'b0},
    '{OP_TICK, 1'b0, 1'b0, EVT_NONE,  1'b0},  // press, run 1..4
    '{OP_TICK, 1'b0, 1'b0, EVT_NONE,  1'b0},
    '{OP_TICK, 1'b0, 1'b0, EVT_NONE,  1'b0},
    '{OP_TICK, 1'b0, 1'b0, EVT_NONE,  1'b0},
    '{OP_TICK, 1'b0, 1'b0, EVT_NONE,  1'b0},  // accepted
    '{OP_TICK, 1'b1, 1'b0, EVT_NONE,  1'b0},  // one-tick glitch
    '{OP_TICK, 1'b0, 1'b0, EVT_NONE,  1'b0},
    '{OP_TICK, 1'b0, 1'b0, EVT_NONE,  1'b0},
    '{OP_TICK, 1'b0, 1'b0, EVT_NONE,  1'b0},
    '{OP_TICK, 1'b0, 1'b0, EVT_NONE,  1'b0},
    '{OP_TICK, 1'b0, 1'b0, EVT_NONE,  1'b0},
    '{OP_TICK, 1'b1, 1'b0, EVT_NONE,  1'b0},  // release, run 1..5
    '{OP_TICK, 1'b1, 1'b0, EVT_NONE,  1'b0},
    '{OP_TICK, 1'b1, 1'b0, EVT_NONE,  1'b0},
    '{OP_TICK, 1'b1, 1'b0, EVT_NONE,  1'b0},
    '{OP_TICK, 1'b1, 1'b0, EVT_NONE,  1'b0},
    '{OP_READ, 1'b0, 1'b1, EVT_SHORT, 1'b0},
    '{OP_READ, 1'b1, 1'b1, EVT_NONE,  1'b0},  // cleared by the read
    '{OP_TICK, 1'b0, 1'b0, EVT_NONE,  1'b0},  // zero thresholds: press and long at once
    '{OP_READ, 1'b1, 1'b1, EVT_LONG,  1'b1},
    '{OP_TICK, 1'b1, 1'b0, EVT_NONE,  1'b0},  // release after long: no short event
    '{OP_READ, 1'b0, 1'b1, EVT_NONE,  1'b0}
  };

  key_debounce_short_long_press_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_key_level    (in_key_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_code  (out_event_code),
    .out_key_pressed (out_key_pressed),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  // Key state update for one item; returns the result it produces
  function automatic kdb_result_t debounce_step(op_t op, logic lvl);
    kdb_result_t res;
    res.event_code = EVT_NONE;
    if (op == OP_TICK) begin
      if (lvl == prev_lvl) begin
        if (run_cnt < deb_thr) run_cnt++;
      end else begin
        prev_lvl = lvl;
        run_cnt  = DEB_W'(1);
      end
      if (run_cnt >= deb_thr) begin
        if (!pressed_st && !lvl) begin
          pressed_st = 1'b1;
          hold_cnt   = '0;
          long_seen  = 1'b0;
        end else if (pressed_st && lvl) begin
          pressed_st = 1'b0;
          if (!long_seen) latched_evt = EVT_SHORT;
          hold_cnt  = '0;
          long_seen = 1'b0;
        end
      end
      // accepting tick counts as the first hold tick
      if (pressed_st) begin
        if (hold_cnt < long_thr) hold_cnt++;
        if (hold_cnt >= long_thr && !long_seen) begin
          long_seen   = 1'b1;
          latched_evt = EVT_LONG;
        end
      end
    end else begin
      res.event_code = latched_evt;
      latched_evt    = EVT_NONE;
    end
    res.key_pressed = pressed_st;
    return res;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Config and input transfers feed the model; result transfers are checked
  always @(posedge clk) begin
    kdb_result_t res;
    kdb_result_t exp_res;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_DEBOUNCE) deb_thr = cfg_data[DEB_W-1:0];
        else long_thr = cfg_data[HOLD_W-1:0];
      end
      if (in_valid && !in_stall) begin
        res = debounce_step(in_operation, in_key_level);
        if (row_typed) begin
          res.event_code  = row_evt;
          res.key_pressed = row_pressed;
        end
        key_results_q.push_back(res);
      end
      if (out_valid && !out_stall) begin
        if (key_results_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: code %0d pressed %0b",
                                  out_event_code, out_key_pressed));
        end else begin
          exp_res = key_results_q.pop_front();
          if (out_event_code !== exp_res.event_code)
            flag_mismatch($sformatf("event_code %0d, expected %0d",
                                    out_event_code, exp_res.event_code));
          if (out_key_pressed !== exp_res.key_pressed)
            flag_mismatch($sformatf("key_pressed %0b, expected %0b",
                                    out_key_pressed, exp_res.key_pressed));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: stall pattern changes per segment, with an occasional long hold-off
  initial begin : receiver
    int   mode;
    int   rx_left;
    int   rx_seg;
    logic hold_armed;
    logic alt;
    mode       = 0;
    rx_left    = 50;
    rx_seg     = 0;
    hold_armed = 1'b0;
    alt        = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && in_valid) begin
        // long hold-off while the sender keeps offering
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_armed = 1'b0;
      end else if (hold_armed) begin
        out_stall <= 1'b0;
      end else begin
        alt = ~alt;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= alt;
        endcase
        rx_left--;
        if (rx_left == 0) begin
          mode    = $urandom_range(0, 3);
          rx_left = $urandom_range(20, 200);
          rx_seg++;
          if (rx_seg % 25 == 3) hold_armed = 1'b1;
        end
      end
    end
  end

  // Offer one item and wait for its transfer; then maybe close the burst
  task automatic send(op_t op, logic lvl, logic typed, evt_t evt, logic pressed);
    int gap;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key_level <= lvl;
    row_typed    <= typed;
    row_evt      <= evt;
    row_pressed  <= pressed;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(0, 15) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (key_results_q.size() != 0);
  endtask

  // Write both thresholds back to back; upper data bits of the debounce write are junk
  task automatic set_thresholds(logic [DEB_W-1:0] deb, logic [HOLD_W-1:0] lng);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_DEBOUNCE;
    cfg_data  <= {8'($urandom), deb};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_IDX_LONG;
    cfg_data  <= lng;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Next random item: press/release segments with bounce, reads and noise
  task automatic pick_item(output op_t op, output logic lvl);
    int dthr;
    int lthr;
    int span;
    op  = OP_TICK;
    lvl = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 7) begin
      op = OP_READ;
      return;
    end
    if ($urandom_range(0, 99) < 4) return;
    if (seg_left == 0) begin
      dthr = (deb_thr == 0) ? 1 : int'(deb_thr);
      lthr = int'(long_thr);
      if ($urandom_range(0, 99) < 15) begin
        // bounce shorter than the debounce threshold
        seg_lvl  = 1'($urandom_range(0, 1));
        seg_left = $urandom_range(1, (dthr > 1) ? ((dthr - 1 < 4) ? dthr - 1 : 4) : 1);
      end else begin
        steady_lvl = ~steady_lvl;
        seg_lvl    = steady_lvl;
        if (!steady_lvl) begin
          if ($urandom_range(0, 1))
            span = dthr + $urandom_range(0, (lthr > 2) ? ((lthr - 2 < 200) ? lthr - 2 : 200) : 0);
          else
            span = dthr + lthr + $urandom_range(0, 5);
          seg_left = (span > 460) ? 460 : span;
        end else begin
          seg_left = dthr + $urandom_range(0, 8);
        end
      end
      if ($urandom_range(0, 1)) begin
        op = OP_READ;
        return;
      end
    end
    seg_left--;
    lvl = seg_lvl;
  endtask

  // Main sequence
  initial begin : sender
    op_t               op;
    logic              lvl;
    logic [DEB_W-1:0]  deb;
    logic [HOLD_W-1:0] lng;
    int                n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at reset thresholds, then at zero thresholds
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (r == DIR_CFG_ROW) begin
        wait_idle();
        set_thresholds('0, '0);
      end
      send(dir_rows[r].op, dir_rows[r].lvl, dir_rows[r].typed,
           dir_rows[r].evt, dir_rows[r].pressed);
    end

    // Random phases, key state carried across threshold changes
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin deb = 8'd1;   lng = 16'd1;     n = 140; end
        1: begin deb = 8'd2;   lng = 16'd8;     n = 140; end
        2: begin deb = 8'd20;  lng = 16'd60;    n = 140; end
        3: begin deb = 8'd3;   lng = 16'd10;    n = 140; end
        4: begin deb = 8'd255; lng = 16'd65535; n = 700; end
        5: begin deb = 8'd0;   lng = 16'd0;     n = 120; end
        default: begin
          deb = 8'($urandom_range(1, 6));
          lng = 16'($urandom_range(1, 40));
          n   = 140;
        end
      endcase
      wait_idle();
      set_thresholds(deb, lng);
      repeat (n) begin
        pick_item(op, lvl);
        send(op, lvl, 1'b0, EVT_NONE, 1'b0);
      end
      // leave a partial low run above the next, lower threshold
      if (p == 2) begin
        repeat (25) send(OP_TICK, 1'b1, 1'b0, EVT_NONE, 1'b0);
        repeat (12) send(OP_TICK, 1'b0, 1'b0, EVT_NONE, 1'b0);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/kdb_pkg.sv
sv/kdb_cfg_regs.sv
sv/kdb_engine.sv
sv/key_debounce_short_long_press_top.sv
bench/tb_top.sv
